FILE: design/hslc_pkg.sv
// Package for the RGB/HSL to RGBA8 converter: item type and fixed-point constants.
// No dependencies; used by every module of the converter.
`default_nettype none

package hslc_pkg;

    localparam int ARG_W = 24;
    localparam int ARG_FRAC_BITS = 8;
    localparam int QF = 20;
    localparam int FIFO_DEPTH = 2;

    localparam logic [23:0] DEN_PCT = 24'd25600;
    localparam logic [23:0] DEN_BARE = 24'd65280;
    localparam logic [23:0] DEN_UNIT = 24'd256;

    typedef struct packed {
        logic            is_hsl;
        logic            with_alpha;
        logic [3:0][23:0] val;
        logic [3:0]      pct;
        logic [3:0]      zero;
        logic [3:0]      full;
    } hslc_item_t;

endpackage

`default_nettype wire

FILE: design/rgb_hsl_to_rgba8_converter_top.sv
// Top level of the RGB/HSL to RGBA8 converter: front end, queue and back end.
// Depends on hslc_pkg, hslc_front, hslc_fifo and hslc_back.
//
//   channel   handshake        payload
//   input     start / busy     is_hsl, with_alpha, argN_value, argN_pct
//   result    done (strobe)    red, green, blue, alpha, alpha_valid
//
// One color is accepted per cycle while busy is low; each result passes through
// the front register, the queue, six arithmetic stages and the output register.
// Reset clears the valid bits, the queue pointers and the queue count only.
// The receiver cannot stall, so the queue drains every cycle and busy stays low.
`default_nettype none

module rgb_hsl_to_rgba8_converter_top #(
    parameter int FIFO_DEPTH = hslc_pkg::FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        is_hsl,
    input  logic        with_alpha,
    input  logic [23:0] arg0_value,
    input  logic        arg0_pct,
    input  logic [23:0] arg1_value,
    input  logic        arg1_pct,
    input  logic [23:0] arg2_value,
    input  logic        arg2_pct,
    input  logic [23:0] arg3_value,
    input  logic        arg3_pct,
    output logic        done,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic        alpha_valid
);
    import hslc_pkg::*;

    hslc_item_t front_item, head_item;
    logic       front_valid, head_valid, fifo_full;

    assign busy = fifo_full;

    hslc_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(fifo_full),
        .is_hsl(is_hsl), .with_alpha(with_alpha),
        .arg0_value(arg0_value), .arg0_pct(arg0_pct),
        .arg1_value(arg1_value), .arg1_pct(arg1_pct),
        .arg2_value(arg2_value), .arg2_pct(arg2_pct),
        .arg3_value(arg3_value), .arg3_pct(arg3_pct),
        .item(front_item), .item_valid(front_valid)
    );

    hslc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n), .push(front_valid), .push_item(front_item),
        .full(fifo_full), .head_valid(head_valid), .head_item(head_item)
    );

    hslc_back u_back (
        .clk(clk), .rst_n(rst_n), .item(head_item), .item_valid(head_valid),
        .done(done), .red(red), .green(green), .blue(blue), .alpha(alpha),
        .alpha_valid(alpha_valid)
    );

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##9 done)
        else $error("Result did not arrive nine cycles after start.");

    a_no_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !alpha_valid) |-> (alpha == 8'd0))
        else $error("Alpha byte not zero without an alpha argument.");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        front_valid |-> !fifo_full)
        else $error("Queue full while the front end holds a word.");
`endif

endmodule

`default_nettype wire

FILE: design/hslc_front.sv
// Front end of the converter: accepts a color word and classifies each channel.
// Depends on hslc_pkg.
`default_nettype none

module hslc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               is_hsl,
    input  logic               with_alpha,
    input  logic [23:0]        arg0_value,
    input  logic               arg0_pct,
    input  logic [23:0]        arg1_value,
    input  logic               arg1_pct,
    input  logic [23:0]        arg2_value,
    input  logic               arg2_pct,
    input  logic [23:0]        arg3_value,
    input  logic               arg3_pct,
    output hslc_pkg::hslc_item_t item,
    output logic               item_valid
);
    import hslc_pkg::*;

    hslc_item_t item_reg, item_next;
    logic       valid_reg;
    logic [23:0] den;

    always_comb
    begin
        item_next.is_hsl = is_hsl;
        item_next.with_alpha = with_alpha;
        item_next.val = {arg3_value, arg2_value, arg1_value, arg0_value};
        item_next.pct = {arg3_pct, arg2_pct, arg1_pct, arg0_pct};
        den = DEN_UNIT;
        for (int k = 0; k < 4; k++)
        begin
            if (k == 3)
                den = item_next.pct[k] ? DEN_PCT : DEN_UNIT;
            else
                den = item_next.pct[k] ? DEN_PCT : DEN_BARE;
            item_next.zero[k] = item_next.val[k][23] || (item_next.val[k] == 24'd0);
            item_next.full[k] = !item_next.val[k][23] && (item_next.val[k] >= den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

FILE: design/hslc_fifo.sv
// Short queue between the front end and the arithmetic back end.
// Depends on hslc_pkg for the item type.
`default_nettype none

module hslc_fifo #(
    parameter int DEPTH = hslc_pkg::FIFO_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hslc_pkg::hslc_item_t push_item,
    output logic               full,
    output logic               head_valid,
    output hslc_pkg::hslc_item_t head_item
);
    import hslc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hslc_item_t      mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop, do_push;

    assign pop = (count_reg != '0);
    assign do_push = push && (count_reg != CW'(DEPTH));
    assign full = (count_reg == CW'(DEPTH));
    assign head_valid = pop;
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !pop)
            count_next = count_reg + CW'(1);
        else if (!do_push && pop)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: design/hslc_back.sv
// Arithmetic back end: pipeline from a classified item to RGBA bytes, ending in the output registers.
// Depends on hslc_pkg.
`default_nettype none

module hslc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  hslc_pkg::hslc_item_t item,
    input  logic               item_valid,
    output logic               done,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic [7:0]         alpha,
    output logic               alpha_valid
);
    import hslc_pkg::*;

    localparam logic signed [33:0] QONE = 34'sd1048576;
    localparam logic signed [33:0] THIRD = 34'sd349525;

    logic [6:0] vld_reg;

    // Stage 1
    logic        s1_hsl_reg, s1_wa_reg, s1_hpct_reg;
    logic [3:0]  s1_zero_reg, s1_full_reg, s1_pct_reg;
    logic [7:0]  s1_dir_reg [4];
    logic [12:0] s1_nx_reg [4];
    logic [29:0] s1_xh_reg;
    logic [30:0] s1_base_reg;
    logic        s1_sz_reg, s1_sf_reg, s1_lz_reg, s1_lf_reg;
    logic [14:0] s1_sv_reg, s1_lv_reg;
    logic [7:0]  s1_dir_next [4];
    logic [12:0] s1_nx_next [4];
    logic [29:0] s1_xh_next;
    logic [30:0] s1_base_next;
    logic [15:0] sum16, aw16;
    logic [23:0] n24;
    logic signed [25:0] v0s, u26;
    logic [24:0] u25;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sum16 = item.val[k][15:0] + 16'd128;
            aw16 = {item.val[k][7:0], 8'h00} - {8'h00, item.val[k][7:0]} + 16'd128;
            s1_dir_next[k] = (k == 3) ? aw16[15:8] : sum16[15:8];
            n24 = {9'd0, item.val[k][14:0]} * 24'd510 + 24'd25600;
            s1_nx_next[k] = n24[23:11];
        end
        v0s = 26'($signed(item.val[0]));
        u26 = v0s + (item.pct[0] ? 26'sd13107200 : 26'sd23592960);
        u25 = u26[24:0];
        s1_xh_next = item.pct[0] ? {5'd0, u25} * 30'd24 : {5'd0, u25} * 30'd17;
        s1_base_next = item.pct[0] ? {6'd0, u25} * 31'd40 : {6'd0, u25} * 31'd11;
    end

    always_ff @(posedge clk)
    begin
        s1_hsl_reg <= item.is_hsl;
        s1_wa_reg <= item.with_alpha;
        s1_hpct_reg <= item.pct[0];
        s1_zero_reg <= item.zero;
        s1_full_reg <= item.full;
        s1_pct_reg <= item.pct;
        s1_dir_reg <= s1_dir_next;
        s1_nx_reg <= s1_nx_next;
        s1_xh_reg <= s1_xh_next;
        s1_base_reg <= s1_base_next;
        s1_sz_reg <= item.val[1][23] || (item.val[1] == 24'd0);
        s1_sf_reg <= !item.val[1][23] && (item.val[1] >= DEN_PCT);
        s1_lz_reg <= item.val[2][23] || (item.val[2] == 24'd0);
        s1_lf_reg <= !item.val[2][23] && (item.val[2] >= DEN_PCT);
        s1_sv_reg <= item.val[1][14:0];
        s1_lv_reg <= item.val[2][14:0];
    end

    // Stage 2
    logic        s2_hsl_reg, s2_wa_reg, s2_hpct_reg;
    logic [7:0]  s2_rb_reg [4];
    logic [25:0] s2_hq_reg;
    logic [30:0] s2_base_reg;
    logic [20:0] s2_s_reg, s2_l_reg;
    logic [7:0]  s2_rb_next [4];
    logic [25:0] rq26;
    logic [60:0] hprod;
    logic [40:0] sprod, lprod;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rq26 = {13'd0, s1_nx_reg[k]} * 26'd5243;
            if (s1_zero_reg[k])
                s2_rb_next[k] = 8'd0;
            else if (s1_full_reg[k])
                s2_rb_next[k] = 8'd255;
            else if (s1_pct_reg[k])
                s2_rb_next[k] = rq26[24:17];
            else
                s2_rb_next[k] = s1_dir_reg[k];
        end
        hprod = {31'd0, s1_xh_reg} *
                (s1_hpct_reg ? 61'd1374389535 : 61'd1527099484);
        sprod = {26'd0, s1_sv_reg} * 41'd42949673;
        lprod = {26'd0, s1_lv_reg} * 41'd42949673;
    end

    always_ff @(posedge clk)
    begin
        s2_hsl_reg <= s1_hsl_reg;
        s2_wa_reg <= s1_wa_reg;
        s2_hpct_reg <= s1_hpct_reg;
        s2_rb_reg <= s2_rb_next;
        s2_hq_reg <= s1_hpct_reg ? hprod[60:35] : {1'b0, hprod[60:36]};
        s2_base_reg <= s1_base_reg;
        s2_s_reg <= s1_sz_reg ? 21'd0 : (s1_sf_reg ? 21'h100000 : sprod[40:20]);
        s2_l_reg <= s1_lz_reg ? 21'd0 : (s1_lf_reg ? 21'h100000 : lprod[40:20]);
    end

    // Stage 3
    logic        s3_hsl_reg, s3_wa_reg;
    logic [7:0]  s3_rb_reg [4];
    logic signed [33:0] s3_t_reg;
    logic [20:0] s3_s_reg, s3_l_reg, s3_ls_reg;
    logic [31:0] tsum;
    logic [41:0] lsprod;

    always_comb
    begin
        tsum = {1'b0, s2_base_reg} + {6'd0, s2_hq_reg};
        lsprod = {21'd0, s2_l_reg} * {21'd0, s2_s_reg};
    end

    always_ff @(posedge clk)
    begin
        s3_hsl_reg <= s2_hsl_reg;
        s3_wa_reg <= s2_wa_reg;
        s3_rb_reg <= s2_rb_reg;
        s3_t_reg <= $signed({2'b00, tsum}) -
                    (s2_hpct_reg ? 34'sd536870912 : 34'sd268435456);
        s3_s_reg <= s2_s_reg;
        s3_l_reg <= s2_l_reg;
        s3_ls_reg <= lsprod[40:20];
    end

    // Stage 4
    logic        s4_hsl_reg, s4_wa_reg;
    logic [7:0]  s4_rb_reg [4];
    logic signed [33:0] s4_t_reg [3];
    logic signed [22:0] s4_q_reg, s4_p_reg;
    logic signed [33:0] s4_t_next [3];
    logic signed [33:0] traw;
    logic signed [22:0] lq, sq, lsq, qv;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            traw = (k == 0) ? s3_t_reg + THIRD : ((k == 1) ? s3_t_reg : s3_t_reg - THIRD);
            if (traw < 34'sd0)
                traw = traw + QONE;
            if (traw > QONE)
                traw = traw - QONE;
            s4_t_next[k] = traw;
        end
        lq = $signed({2'b00, s3_l_reg});
        sq = $signed({2'b00, s3_s_reg});
        lsq = $signed({2'b00, s3_ls_reg});
        qv = ((lq <<< 1) < 23'sd1048576) ? lq + lsq : lq + sq - lsq;
    end

    always_ff @(posedge clk)
    begin
        s4_hsl_reg <= s3_hsl_reg;
        s4_wa_reg <= s3_wa_reg;
        s4_rb_reg <= s3_rb_reg;
        s4_t_reg <= s4_t_next;
        s4_q_reg <= qv;
        s4_p_reg <= (lq <<< 1) - qv;
    end

    // Stage 5
    logic        s5_hsl_reg, s5_wa_reg;
    logic [7:0]  s5_rb_reg [4];
    logic [2:0]  s5_mul_reg;
    logic signed [36:0] s5_m_reg [3];
    logic signed [22:0] s5_hold_reg [3];
    logic signed [22:0] s5_p_reg, s5_d_reg;
    logic [2:0]  s5_mul_next;
    logic signed [36:0] s5_m_next [3];
    logic signed [22:0] s5_hold_next [3];
    logic signed [36:0] t6, t2, t3;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t6 = 37'(s4_t_reg[k]) * 37'sd6;
            t2 = 37'(s4_t_reg[k]) * 37'sd2;
            t3 = 37'(s4_t_reg[k]) * 37'sd3;
            s5_mul_next[k] = 1'b0;
            s5_m_next[k] = t6;
            s5_hold_next[k] = s4_p_reg;
            if (t6 < 37'sd1048576)
                s5_mul_next[k] = 1'b1;
            else if (t2 < 37'sd1048576)
                s5_hold_next[k] = s4_q_reg;
            else if (t3 < 37'sd2097152)
            begin
                s5_mul_next[k] = 1'b1;
                s5_m_next[k] = 37'sd4194304 - t6;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s5_hsl_reg <= s4_hsl_reg;
        s5_wa_reg <= s4_wa_reg;
        s5_rb_reg <= s4_rb_reg;
        s5_mul_reg <= s5_mul_next;
        s5_m_reg <= s5_m_next;
        s5_hold_reg <= s5_hold_next;
        s5_p_reg <= s4_p_reg;
        s5_d_reg <= s4_q_reg - s4_p_reg;
    end

    // Stage 6
    logic        s6_hsl_reg, s6_wa_reg;
    logic [7:0]  s6_rb_reg [4];
    logic [2:0]  s6_mul_reg;
    logic signed [59:0] s6_prod_reg [3];
    logic signed [22:0] s6_hold_reg [3];
    logic signed [22:0] s6_p_reg;
    logic signed [59:0] s6_prod_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s6_prod_next[k] = 60'(s5_d_reg) * 60'(s5_m_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        s6_hsl_reg <= s5_hsl_reg;
        s6_wa_reg <= s5_wa_reg;
        s6_rb_reg <= s5_rb_reg;
        s6_mul_reg <= s5_mul_reg;
        s6_prod_reg <= s6_prod_next;
        s6_hold_reg <= s5_hold_reg;
        s6_p_reg <= s5_p_reg;
    end

    // Stage 7: sector result to byte and output registers
    logic [7:0]  hb [3];
    logic signed [40:0] xv;
    logic [28:0] w29;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;
    logic        av_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            xv = s6_mul_reg[k] ? 41'(s6_p_reg) + 41'(s6_prod_reg[k] >>> 20)
                               : 41'(s6_hold_reg[k]);
            w29 = {xv[20:0], 8'h00} - {8'h00, xv[20:0]} + 29'd524288;
            if (xv <= 41'sd0)
                hb[k] = 8'd0;
            else if (xv >= 41'sd1048576)
                hb[k] = 8'd255;
            else
                hb[k] = w29[27:20];
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg <= s6_hsl_reg ? hb[0] : s6_rb_reg[0];
        green_reg <= s6_hsl_reg ? hb[1] : s6_rb_reg[1];
        blue_reg <= s6_hsl_reg ? hb[2] : s6_rb_reg[2];
        alpha_reg <= s6_wa_reg ? s6_rb_reg[3] : 8'd0;
        av_reg <= s6_wa_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[5:0], item_valid};
        end
    end

    assign done = vld_reg[6];
    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;
    assign alpha = alpha_reg;
    assign alpha_valid = av_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the RGB/HSL to RGBA8 converter top level.
// Drives colors through start/busy and checks every done word against a fixed-point predictor.
// Depends only on the converter RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit        hsl;
        bit        has_a;
        bit [23:0] v [4];
        bit        pct [4];
    } color_t;

    typedef struct {
        bit [7:0] r;
        bit [7:0] g;
        bit [7:0] b;
        bit [7:0] a;
        bit       av;
    } rgba_t;

    localparam longint QONE = 64'sd1 << 20;
    localparam longint DEN_PCT = 64'sd100 << 8;
    localparam longint DEN_BARE = 64'sd255 << 8;
    localparam longint DEN_DEG = 64'sd360 << 8;
    localparam longint DEN_UNIT = 64'sd1 << 8;
    localparam int LIMIT = 200000;

    logic clk, rst_n, start, busy, done;
    logic is_hsl, with_alpha, arg0_pct, arg1_pct, arg2_pct, arg3_pct;
    logic [23:0] arg0_value, arg1_value, arg2_value, arg3_value;
    logic [7:0] red, green, blue, alpha;
    logic alpha_valid;

    color_t pending_colors[$];
    rgba_t expected_rgba[$];
    int mismatches = 0;
    int gap_left = 0;
    int cycles = 0;
    bit no_idle = 0;
    bit stim_done = 0;

    rgb_hsl_to_rgba8_converter_top DUT (.*);

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q -= 1;
        return q;
    endfunction

    function automatic bit [7:0] ratio_byte(longint n, longint d);
        if (n <= 0) return 8'd0;
        if (n >= d) return 8'd255;
        return 8'((510 * n + d) / (2 * d));
    endfunction

    function automatic bit [7:0] unit_byte(longint x);
        if (x <= 0) return 8'd0;
        if (x >= QONE) return 8'd255;
        return 8'((x * 255 + (QONE >> 1)) >>> 20);
    endfunction

    function automatic longint clamp_unit(longint x);
        return x < 0 ? 64'sd0 : (x > QONE ? QONE : x);
    endfunction

    function automatic longint hue_channel(longint p, longint q, longint t);
        if (t < 0) t += QONE;
        if (t > QONE) t -= QONE;
        if (t * 6 < QONE) return p + fdiv((q - p) * 6 * t, QONE);
        if (t * 2 < QONE) return q;
        if (t * 3 < 2 * QONE) return p + fdiv((q - p) * (4 * QONE - 6 * t), QONE);
        return p;
    endfunction

    function automatic rgba_t convert_color(color_t c);
        rgba_t o;
        longint v [4];
        longint t, s, l, ls, q, p, third;
        for (int k = 0; k < 4; k++) v[k] = longint'(signed'(c.v[k]));
        if (!c.hsl) begin
            o.r = ratio_byte(v[0], c.pct[0] ? DEN_PCT : DEN_BARE);
            o.g = ratio_byte(v[1], c.pct[1] ? DEN_PCT : DEN_BARE);
            o.b = ratio_byte(v[2], c.pct[2] ? DEN_PCT : DEN_BARE);
        end
        else begin
            t = fdiv(v[0] * QONE, c.pct[0] ? DEN_PCT : DEN_DEG);
            s = clamp_unit(fdiv(v[1] * QONE, DEN_PCT));
            l = clamp_unit(fdiv(v[2] * QONE, DEN_PCT));
            ls = (l * s) >>> 20;
            q = (2 * l < QONE) ? l + ls : l + s - ls;
            p = 2 * l - q;
            third = QONE / 3;
            o.r = unit_byte(hue_channel(p, q, t + third));
            o.g = unit_byte(hue_channel(p, q, t));
            o.b = unit_byte(hue_channel(p, q, t - third));
        end
        o.a = c.has_a ? ratio_byte(v[3], c.pct[3] ? DEN_PCT : DEN_UNIT) : 8'd0;
        o.av = c.has_a;
        return o;
    endfunction

    function automatic bit [23:0] fixed_arg(int whole);
        return 24'(whole * 256 + int'($urandom_range(0, 255)));
    endfunction

    function automatic color_t random_color();
        color_t c;
        int sel;
        c.hsl = 1'($urandom_range(0, 1));
        c.has_a = 1'($urandom_range(0, 1));
        for (int k = 0; k < 4; k++) begin
            c.pct[k] = 1'($urandom_range(0, 1));
            sel = int'($urandom_range(0, 9));
            if (sel == 0) c.v[k] = 24'($urandom);
            else if (sel == 1) c.v[k] = fixed_arg(int'($urandom_range(0, 1440)) - 720);
            else if (k == 0 && c.hsl) c.v[k] = fixed_arg(int'($urandom_range(0, 400)) - 20);
            else if (k == 3 && !c.pct[3]) c.v[k] = 24'($urandom_range(0, 300));
            else if (c.pct[k] || c.hsl) c.v[k] = fixed_arg(int'($urandom_range(0, 105)) - 2);
            else c.v[k] = fixed_arg(int'($urandom_range(0, 260)) - 2);
        end
        return c;
    endfunction

    function automatic color_t make_color(bit h, bit a, int v0, int v1, int v2, int v3,
                                          bit [3:0] pc);
        color_t c;
        c.hsl = h;
        c.has_a = a;
        c.v[0] = 24'(v0);
        c.v[1] = 24'(v1);
        c.v[2] = 24'(v2);
        c.v[3] = 24'(v3);
        for (int k = 0; k < 4; k++) c.pct[k] = pc[k];
        return c;
    endfunction

    function automatic void add_pending(color_t c);
        pending_colors.insert(pending_colors.size(), c);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        add_pending(make_color(0, 1, 0, 255 * 256, 128 * 256, 256, 4'b0000));
        add_pending(make_color(0, 1, -8388608, 8388607, 127, 8388607, 4'b0000));
        add_pending(make_color(0, 1, 50 * 256, 100 * 256, 8388607, 50 * 256, 4'b1111));
        add_pending(make_color(0, 0, 1, -1, 65407, 12345, 4'b1010));
        add_pending(make_color(1, 1, 0, 100 * 256, 50 * 256, 128, 4'b0000));
        add_pending(make_color(1, 1, 120 * 256, 100 * 256, 50 * 256, -5, 4'b0110));
        add_pending(make_color(1, 0, 240 * 256, 100 * 256, 50 * 256, 0, 4'b0000));
        add_pending(make_color(1, 1, 50 * 256, 50 * 256, 25 * 256, 0, 4'b1001));
        add_pending(make_color(1, 1, -120 * 256, 200 * 256, 75 * 256, 300, 4'b0000));
        add_pending(make_color(1, 1, 600 * 256, 80 * 256, 40 * 256, 0, 4'b0000));
        add_pending(make_color(1, 1, -8388608, 8388607, -8388608, -1, 4'b0001));
        add_pending(make_color(1, 0, 8388607, -200, 8388607, 0, 4'b0111));
        add_pending(make_color(1, 1, 60 * 256, 0, 100 * 256, 0, 4'b1000));
        add_pending(make_color(1, 1, 359 * 256 + 255, 100 * 256, 60 * 256, 0, 4'b0000));
        add_pending(make_color(1, 1, 180 * 256, 100 * 256, 50 * 256, 0, 4'b0001));
        for (int i = 0; i < 1450; i++) add_pending(random_color());
    end

    always @(posedge clk)
    begin
        if (!rst_n) begin
            start <= 1'b0;
            is_hsl <= 1'b0;
            with_alpha <= 1'b0;
            arg0_value <= '0;
            arg1_value <= '0;
            arg2_value <= '0;
            arg3_value <= '0;
            arg0_pct <= 1'b0;
            arg1_pct <= 1'b0;
            arg2_pct <= 1'b0;
            arg3_pct <= 1'b0;
        end
        else begin
            if (start && !busy)
                expected_rgba.insert(expected_rgba.size(),
                                     convert_color(pending_colors.pop_front()));
            if (start && busy) begin
            end
            else if (pending_colors.size() == 0) begin
                start <= 1'b0;
                stim_done <= 1'b1;
            end
            else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (!no_idle && pending_colors.size() > 100 && $urandom_range(0, 7) == 0) begin
                gap_left <= int'($urandom_range(0, 8));
                start <= 1'b0;
            end
            else begin
                start <= 1'b1;
                is_hsl <= pending_colors[0].hsl;
                with_alpha <= pending_colors[0].has_a;
                arg0_value <= pending_colors[0].v[0];
                arg1_value <= pending_colors[0].v[1];
                arg2_value <= pending_colors[0].v[2];
                arg3_value <= pending_colors[0].v[3];
                arg0_pct <= pending_colors[0].pct[0];
                arg1_pct <= pending_colors[0].pct[1];
                arg2_pct <= pending_colors[0].pct[2];
                arg3_pct <= pending_colors[0].pct[3];
            end
            if (pending_colors.size() <= 100) no_idle <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        rgba_t e;
        if (rst_n && done) begin
            if (expected_rgba.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("tb: unexpected word %h %h %h %h %b",
                                               red, green, blue, alpha, alpha_valid);
            end
            else begin
                e = expected_rgba.pop_front();
                if (red !== e.r || green !== e.g || blue !== e.b || alpha !== e.a
                    || alpha_valid !== e.av) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                                 e.r, e.g, e.b, e.a, e.av,
                                 red, green, blue, alpha, alpha_valid);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done);
        wait (expected_rgba.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_rgba.size() == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end
endmodule

`default_nettype wire
